@@ rtl/assert_macros.svh @@
// Assertion helpers, sampled on clk_i and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge.
`define CHK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on the same edge.
`define CHK_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/bslh_pkg.sv @@
`default_nettype none

package bslh_pkg;

  localparam logic [31:0] GoldenRatio = 32'h9e3779b9;
  localparam logic [3:0]  BlockBytes  = 4'd12;
  localparam logic [3:0]  LastInBlock = 4'd11;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } abc_t;

  // State handed to the finalization stage.
  typedef struct packed {
    abc_t        abc;
    logic [31:0] p0;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] len;
  } fin_t;

  function automatic abc_t mix(abc_t v);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    abc_t        r;
    a = v.a;
    b = v.b;
    c = v.c;
    a = a - b; a = a - c; a = a ^ (c >> 13);
    b = b - c; b = b - a; b = b ^ (a << 8);
    c = c - a; c = c - b; c = c ^ (b >> 13);
    a = a - b; a = a - c; a = a ^ (c >> 12);
    b = b - c; b = b - a; b = b ^ (a << 16);
    c = c - a; c = c - b; c = c ^ (b >> 5);
    a = a - b; a = a - c; a = a ^ (c >> 3);
    b = b - c; b = b - a; b = b ^ (a << 10);
    c = c - a; c = c - b; c = c ^ (b >> 15);
    r.a = a;
    r.b = b;
    r.c = c;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bslh_absorb.sv @@
`default_nettype none

module bslh_absorb (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          last_byte_i,
  input  wire logic          message_empty_i,
  output logic               fin_valid_o,
  output bslh_pkg::fin_t     fin_o,
  input  wire logic          fin_stall_i
);

  logic        in_vld_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        empty_q;

  bslh_pkg::abc_t abc_q, abc_d, abc_n;
  logic [31:0] p_q [3];
  logic [31:0] p_d [3];
  logic [31:0] p_m [3];
  logic [31:0] p_n [3];
  logic [3:0]  pos_q, pos_d, pos_eff, pos_n;
  logic [31:0] len_q, len_d, len_n;
  logic [31:0] byte_sh;
  logic        fin_gen;
  logic        move;
  bslh_pkg::abc_t abs_in;

  assign fin_gen     = empty_q || last_q;
  assign move        = in_vld_q && (!fin_gen || !fin_stall_i);
  assign in_stall_o  = in_vld_q && !move;
  assign fin_valid_o = in_vld_q && fin_gen;

  always_comb begin
    pos_eff = (pos_q >= bslh_pkg::BlockBytes) ? 4'd0 : pos_q;
    byte_sh = {24'd0, byte_q} << {pos_eff[1:0], 3'b000};
    p_m[0]  = p_q[0];
    p_m[1]  = p_q[1];
    p_m[2]  = p_q[2];
    unique case (pos_eff[3:2])
      2'd0:    p_m[0] = p_q[0] | byte_sh;
      2'd1:    p_m[1] = p_q[1] | byte_sh;
      default: p_m[2] = p_q[2] | byte_sh;
    endcase
    len_n    = len_q + 32'd1;
    abs_in.a = abc_q.a + p_m[0];
    abs_in.b = abc_q.b + p_m[1];
    abs_in.c = abc_q.c + p_m[2];
    if (pos_eff == bslh_pkg::LastInBlock) begin
      abc_n  = bslh_pkg::mix(abs_in);
      p_n[0] = '0;
      p_n[1] = '0;
      p_n[2] = '0;
      pos_n  = 4'd0;
    end else begin
      abc_n  = abc_q;
      p_n    = p_m;
      pos_n  = pos_eff + 4'd1;
    end
  end

  always_comb begin
    if (empty_q) begin
      fin_o.abc = abc_q;
      fin_o.p0  = p_q[0];
      fin_o.p1  = p_q[1];
      fin_o.p2  = p_q[2];
      fin_o.len = len_q;
    end else begin
      fin_o.abc = abc_n;
      fin_o.p0  = p_n[0];
      fin_o.p1  = p_n[1];
      fin_o.p2  = p_n[2];
      fin_o.len = len_n;
    end
  end

  always_comb begin
    abc_d = abc_q;
    p_d   = p_q;
    pos_d = pos_q;
    len_d = len_q;
    if (move) begin
      if (fin_gen) begin
        abc_d = '{a: bslh_pkg::GoldenRatio, b: bslh_pkg::GoldenRatio,
                  c: bslh_pkg::GoldenRatio};
        p_d[0] = '0;
        p_d[1] = '0;
        p_d[2] = '0;
        pos_d  = 4'd0;
        len_d  = '0;
      end else begin
        abc_d = abc_n;
        p_d   = p_n;
        pos_d = pos_n;
        len_d = len_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      abc_q    <= '{a: bslh_pkg::GoldenRatio, b: bslh_pkg::GoldenRatio,
                    c: bslh_pkg::GoldenRatio};
      p_q[0]   <= '0;
      p_q[1]   <= '0;
      p_q[2]   <= '0;
      pos_q    <= 4'd0;
      len_q    <= '0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      abc_q <= abc_d;
      p_q   <= p_d;
      pos_q <= pos_d;
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q  <= data_byte_i;
      last_q  <= last_byte_i;
      empty_q <= message_empty_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bslh_final.sv @@
`default_nettype none

module bslh_final (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fin_valid_i,
  input  wire bslh_pkg::fin_t  fin_i,
  output logic                 fin_stall_o,
  output logic                 out_valid_o,
  output logic [31:0]          hash_value_o,
  input  wire logic            out_stall_i
);

  logic           fin_vld_q;
  bslh_pkg::fin_t fin_q;
  logic           out_vld_q, out_vld_d;
  logic [31:0]    hash_q;
  logic           out_free;
  logic           load_out;
  bslh_pkg::abc_t tail;
  bslh_pkg::abc_t mixed;

  assign out_free    = !out_vld_q || !out_stall_i;
  assign load_out    = fin_vld_q && out_free;
  assign fin_stall_o = fin_vld_q && !out_free;

  always_comb begin
    tail.a = fin_q.abc.a + fin_q.p0;
    tail.b = fin_q.abc.b + fin_q.p1;
    tail.c = fin_q.abc.c + fin_q.len + (fin_q.p2 << 8);
    mixed  = bslh_pkg::mix(tail);
  end

  always_comb begin
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && out_stall_i) begin
      out_vld_d = 1'b1;
    end else begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!fin_stall_o) begin
        fin_vld_q <= fin_valid_i;
      end
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!fin_stall_o && fin_valid_i) begin
      fin_q <= fin_i;
    end
    if (load_out) begin
      hash_q <= mixed.c;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign hash_value_o = hash_q;

endmodule

`default_nettype wire

@@ rtl/byte_stream_lookup2_hash_unit.sv @@
// Streaming lookup2 hash, one message byte per input word.
// Throughput: one input word per cycle while in_stall_o is low, including words
// that complete a block. Input word, finalization state and hash word are each
// registered, so block mixing and final mixing sit in separate register stages.
// Reset (rst_ni low, asynchronous) empties the pipeline and restores a, b, c
// to the golden-ratio constant with an empty pending block and zero length.
`default_nettype none
`include "assert_macros.svh"

module byte_stream_lookup2_hash_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic        message_empty_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      hash_value_o
);

  logic           fin_valid;
  logic           fin_stall;
  bslh_pkg::fin_t fin;

  bslh_absorb u_absorb (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .message_empty_i (message_empty_i),
    .fin_valid_o     (fin_valid),
    .fin_o           (fin),
    .fin_stall_i     (fin_stall)
  );

  bslh_final u_final (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fin_valid_i  (fin_valid),
    .fin_i        (fin),
    .fin_stall_o  (fin_stall),
    .out_valid_o  (out_valid_o),
    .hash_value_o (hash_value_o),
    .out_stall_i  (out_stall_i)
  );

  `CHK_IMPLY(a_in_stall_src, in_stall_o, fin_valid && fin_stall, "in stall without fin stall")
  `CHK_IMPLY(a_fin_stall_src, fin_stall, out_valid_o && out_stall_i, "fin stall without out stall")
  `CHK_ALWAYS(a_no_stall_idle, !(in_stall_o && !fin_valid), "input stalls on non-finishing word")

endmodule

`default_nettype wire
